FILE: rtl/tfab_pkg.sv
// Shared constants, command codes and control types of the face adjacency builder.
package tfab_pkg;

    localparam int MAX_FACES_DEF   = 1024;
    localparam int VERTEX_BITS_DEF = 16;

    localparam int VERT_W  = 16;
    localparam int QFACE_W = 10;
    localparam int FCNT_W  = 11;
    localparam int LCNT_W  = 12;
    localparam int DEG_W   = 3;
    localparam int NBR_W   = 10;
    localparam int MAX_DEG = 6;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_BUILD = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    localparam logic [1:0] SEL_E = 2'd0;
    localparam logic [1:0] SEL_B = 2'd1;
    localparam logic [1:0] SEL_C = 2'd2;

    typedef struct packed {
        logic       ld_we;
        logic       st_we;
        logic [1:0] src;
        logic [1:0] dst;
    } t_edge_ctl;

endpackage

FILE: rtl/tfab_edge_mem.sv
// Edge store and the two merge sort buffers, with two registered read ports.
module tfab_edge_mem #(
    parameter int DEPTH = 3 * tfab_pkg::MAX_FACES_DEF,
    parameter int EW    = 42,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  tfab_pkg::t_edge_ctl  i_ctl,
    input  logic [AW-1:0]        i_ld_addr,
    input  logic [EW-1:0]        i_ld_data,
    input  logic [AW-1:0]        i_st_addr,
    input  logic [EW-1:0]        i_st_data,
    input  logic [AW-1:0]        i_rd_addr0,
    input  logic [AW-1:0]        i_rd_addr1,
    output logic [EW-1:0]        o_rd_data0,
    output logic [EW-1:0]        o_rd_data1
);

    logic [EW-1:0] r_mem_e [DEPTH];
    logic [EW-1:0] r_mem_b [DEPTH];
    logic [EW-1:0] r_mem_c [DEPTH];
    logic [EW-1:0] r_e0, r_e1, r_b0, r_b1, r_c0, r_c1;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_we) begin
            r_mem_e[i_ld_addr] <= i_ld_data;
        end
        r_e0 <= r_mem_e[i_rd_addr0];
        r_e1 <= r_mem_e[i_rd_addr1];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.st_we && i_ctl.dst == tfab_pkg::SEL_B) begin
            r_mem_b[i_st_addr] <= i_st_data;
        end
        r_b0 <= r_mem_b[i_rd_addr0];
        r_b1 <= r_mem_b[i_rd_addr1];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.st_we && i_ctl.dst == tfab_pkg::SEL_C) begin
            r_mem_c[i_st_addr] <= i_st_data;
        end
        r_c0 <= r_mem_c[i_rd_addr0];
        r_c1 <= r_mem_c[i_rd_addr1];
    end

    always_comb begin
        case (i_ctl.src)
            tfab_pkg::SEL_B: begin
                o_rd_data0 = r_b0;
                o_rd_data1 = r_b1;
            end
            tfab_pkg::SEL_C: begin
                o_rd_data0 = r_c0;
                o_rd_data1 = r_c1;
            end
            default: begin
                o_rd_data0 = r_e0;
                o_rd_data1 = r_e1;
            end
        endcase
    end

endmodule

FILE: rtl/tfab_adj_mem.sv
// Per-face degree and neighbour list memory with clear and push-front update.
module tfab_adj_mem #(
    parameter int FACES = tfab_pkg::MAX_FACES_DEF,
    parameter int FB    = $clog2(FACES),
    parameter int RW    = tfab_pkg::DEG_W + tfab_pkg::MAX_DEG * FB
) (
    input  logic          i_clk,
    input  logic [FB-1:0] i_addr,
    input  logic          i_clr,
    input  logic          i_push,
    input  logic [FB-1:0] i_nbr,
    output logic [RW-1:0] o_row
);

    logic [RW-1:0] r_mem [FACES];
    logic [RW-1:0] r_row;
    logic [tfab_pkg::DEG_W-1:0] deg;
    logic [tfab_pkg::DEG_W-1:0] n_deg;
    logic [RW-1:0] n_row;

    always_comb begin
        deg   = r_row[RW-1 -: tfab_pkg::DEG_W];
        n_deg = (deg < tfab_pkg::DEG_W'(tfab_pkg::MAX_DEG))
                ? deg + tfab_pkg::DEG_W'(1) : deg;
        n_row = {n_deg, r_row[(tfab_pkg::MAX_DEG-1)*FB-1:0], i_nbr};
    end

    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            r_mem[i_addr] <= '0;
        end else if (i_push) begin
            r_mem[i_addr] <= n_row;
        end
        r_row <= r_mem[i_addr];
    end

    assign o_row = r_row;

endmodule

FILE: rtl/triangle_face_adjacency_builder.sv
// Top level of the triangle face adjacency builder: sequencer, merge unit, result register.
//
// Input channel (i_valid/o_ready) carries one command beat: load a triangle,
// build adjacency, query a face, or clear. Output channel (o_valid/i_ready)
// carries one result beat for each build and each query; loads and clears
// give none.
// Load: edges written one per cycle into the edge store, which has a single write port.
// Clear: empties the face count, overflow flag and link count. Query: the face row
// is read from the degree table, then written to the result register.
// Build: zero every entry of the degree table, then a bottom-up merge sort over
// n = 3 * faces edges in ceil(log2 n) passes, then a scan of adjacent sorted pairs
// that pushes each link found into both faces' rows, then write the result register.
// One command is worked on at a time; o_ready is high only when idle.
// Reset empties the face count, overflow flag and link count; every degree
// reads as zero until the first build. A stalled receiver holds the result
// register, and a following build or query waits for it to drain.
module triangle_face_adjacency_builder #(
    parameter int MAX_FACES   = tfab_pkg::MAX_FACES_DEF,
    parameter int VERTEX_BITS = tfab_pkg::VERTEX_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_kind,
    input  logic [tfab_pkg::VERT_W-1:0]   i_vertex_a,
    input  logic [tfab_pkg::VERT_W-1:0]   i_vertex_b,
    input  logic [tfab_pkg::VERT_W-1:0]   i_vertex_c,
    input  logic [tfab_pkg::QFACE_W-1:0]  i_query_face,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [tfab_pkg::FCNT_W-1:0]   o_face_count,
    output logic [tfab_pkg::LCNT_W-1:0]   o_link_count,
    output logic                          o_overflow,
    output logic [tfab_pkg::DEG_W-1:0]    o_neighbour_count,
    output logic [tfab_pkg::NBR_W-1:0]    o_neighbour_0,
    output logic [tfab_pkg::NBR_W-1:0]    o_neighbour_1,
    output logic [tfab_pkg::NBR_W-1:0]    o_neighbour_2,
    output logic [tfab_pkg::NBR_W-1:0]    o_neighbour_3,
    output logic [tfab_pkg::NBR_W-1:0]    o_neighbour_4,
    output logic [tfab_pkg::NBR_W-1:0]    o_neighbour_5
);

    localparam int FB    = $clog2(MAX_FACES);
    localparam int CW    = $clog2(MAX_FACES + 1);
    localparam int VW    = (VERTEX_BITS < tfab_pkg::VERT_W) ? VERTEX_BITS : tfab_pkg::VERT_W;
    localparam int EW    = 2 * VW + FB;
    localparam int DEPTH = 3 * MAX_FACES;
    localparam int EAW   = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1) + 2;
    localparam int LW    = $clog2(DEPTH);
    localparam int RW    = tfab_pkg::DEG_W + tfab_pkg::MAX_DEG * FB;
    localparam int DW    = tfab_pkg::DEG_W;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_LOAD1  = 4'd1;
    localparam logic [3:0] ST_LOAD2  = 4'd2;
    localparam logic [3:0] ST_CLRDEG = 4'd3;
    localparam logic [3:0] ST_RUN    = 4'd4;
    localparam logic [3:0] ST_MRD    = 4'd5;
    localparam logic [3:0] ST_MWR    = 4'd6;
    localparam logic [3:0] ST_SRD    = 4'd7;
    localparam logic [3:0] ST_SCMP   = 4'd8;
    localparam logic [3:0] ST_PUWAIT = 4'd9;
    localparam logic [3:0] ST_PUWR   = 4'd10;
    localparam logic [3:0] ST_PVWAIT = 4'd11;
    localparam logic [3:0] ST_PVWR   = 4'd12;
    localparam logic [3:0] ST_OUT    = 4'd13;
    localparam logic [3:0] ST_QWAIT  = 4'd14;
    localparam logic [3:0] ST_QOUT   = 4'd15;

    function automatic logic [EW-1:0] mk_edge(input logic [VW-1:0] p,
                                              input logic [VW-1:0] q,
                                              input logic [FB-1:0] f);
        return (p < q) ? {p, q, f} : {q, p, f};
    endfunction

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_drop, n_drop;
    logic [LW-1:0] r_links, n_links;
    logic          r_deg_ok, n_deg_ok;
    logic [VW-1:0] r_va, n_va, r_vb, n_vb, r_vc, n_vc;
    logic [FB-1:0] r_face, n_face;
    logic [EAW-1:0] r_base, n_base;
    logic [NW-1:0] r_n, n_n, r_w, n_w, r_s, n_s;
    logic [NW-1:0] r_i, n_i, r_j, n_j, r_k, n_k, r_m, n_m, r_e, n_e;
    logic [1:0]    r_src, n_src, r_dst, n_dst;
    logic [FB-1:0] r_adj_addr, n_adj_addr;
    logic [FB-1:0] r_pu, n_pu, r_pv, n_pv;
    logic          r_q_ok, n_q_ok;

    logic                       r_o_valid, n_o_valid;
    logic [tfab_pkg::FCNT_W-1:0] r_o_face, n_o_face;
    logic [tfab_pkg::LCNT_W-1:0] r_o_links, n_o_links;
    logic                       r_o_ovf, n_o_ovf;
    logic [DW-1:0]              r_o_ncnt, n_o_ncnt;
    logic [tfab_pkg::NBR_W-1:0] r_o_nbr [tfab_pkg::MAX_DEG];
    logic [tfab_pkg::NBR_W-1:0] n_o_nbr [tfab_pkg::MAX_DEG];

    tfab_pkg::t_edge_ctl edge_ctl;
    logic [EAW-1:0] ld_addr;
    logic [EW-1:0]  ld_data;
    logic [EW-1:0]  st_data;
    logic [EW-1:0]  rd0, rd1;
    logic [RW-1:0]  adj_row;
    logic [DW-1:0]  row_deg;

    logic          accept, out_free, room, take_j, same;
    logic [EAW-1:0] base_now;
    logic [NW-1:0] s_w, s_2w, w2, k1, j1;

    assign o_ready  = (r_state == ST_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_o_valid || i_ready;
    assign room     = (r_count < CW'(MAX_FACES));
    assign base_now = EAW'({r_count, 1'b0}) + EAW'(r_count);
    assign row_deg  = adj_row[RW-1 -: DW];

    assign same   = (rd0[EW-1:FB] == rd1[EW-1:FB]);
    assign take_j = (r_i >= r_m) || ((r_j < r_e) && (rd1[EW-1:FB] < rd0[EW-1:FB]));
    assign st_data = take_j ? rd1 : rd0;
    assign s_w    = r_s + r_w;
    assign w2     = {r_w[NW-2:0], 1'b0};
    assign s_2w   = r_s + w2;
    assign k1     = r_k + NW'(1);
    assign j1     = r_j + NW'(1);

    always_comb begin
        edge_ctl.ld_we = (accept && i_kind == tfab_pkg::KIND_LOAD && room)
                         || r_state == ST_LOAD1 || r_state == ST_LOAD2;
        edge_ctl.st_we = (r_state == ST_MWR);
        edge_ctl.src   = r_src;
        edge_ctl.dst   = r_dst;
        case (r_state)
            ST_LOAD1: begin
                ld_addr = r_base + EAW'(1);
                ld_data = mk_edge(r_vb, r_vc, r_face);
            end
            ST_LOAD2: begin
                ld_addr = r_base + EAW'(2);
                ld_data = mk_edge(r_vc, r_va, r_face);
            end
            default: begin
                ld_addr = base_now;
                ld_data = mk_edge(VW'(i_vertex_a), VW'(i_vertex_b), FB'(r_count));
            end
        endcase
    end

    tfab_edge_mem #(
        .DEPTH (DEPTH),
        .EW    (EW),
        .AW    (EAW)
    ) u_edge_mem (
        .i_clk      (i_clk),
        .i_ctl      (edge_ctl),
        .i_ld_addr  (ld_addr),
        .i_ld_data  (ld_data),
        .i_st_addr  (r_k[EAW-1:0]),
        .i_st_data  (st_data),
        .i_rd_addr0 (r_i[EAW-1:0]),
        .i_rd_addr1 (r_j[EAW-1:0]),
        .o_rd_data0 (rd0),
        .o_rd_data1 (rd1)
    );

    tfab_adj_mem #(
        .FACES (MAX_FACES),
        .FB    (FB),
        .RW    (RW)
    ) u_adj_mem (
        .i_clk  (i_clk),
        .i_addr (r_adj_addr),
        .i_clr  (r_state == ST_CLRDEG),
        .i_push (r_state == ST_PUWR || r_state == ST_PVWR),
        .i_nbr  ((r_state == ST_PUWR) ? r_pv : r_pu),
        .o_row  (adj_row)
    );

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_drop     = r_drop;
        n_links    = r_links;
        n_deg_ok   = r_deg_ok;
        n_va       = r_va;
        n_vb       = r_vb;
        n_vc       = r_vc;
        n_face     = r_face;
        n_base     = r_base;
        n_n        = r_n;
        n_w        = r_w;
        n_s        = r_s;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_m        = r_m;
        n_e        = r_e;
        n_src      = r_src;
        n_dst      = r_dst;
        n_adj_addr = r_adj_addr;
        n_pu       = r_pu;
        n_pv       = r_pv;
        n_q_ok     = r_q_ok;
        n_o_valid  = r_o_valid && !i_ready;
        n_o_face   = r_o_face;
        n_o_links  = r_o_links;
        n_o_ovf    = r_o_ovf;
        n_o_ncnt   = r_o_ncnt;
        for (int t = 0; t < tfab_pkg::MAX_DEG; t++) begin
            n_o_nbr[t] = r_o_nbr[t];
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_kind)
                        tfab_pkg::KIND_LOAD: begin
                            if (room) begin
                                n_va    = VW'(i_vertex_a);
                                n_vb    = VW'(i_vertex_b);
                                n_vc    = VW'(i_vertex_c);
                                n_face  = FB'(r_count);
                                n_base  = base_now;
                                n_count = r_count + CW'(1);
                                n_state = ST_LOAD1;
                            end else begin
                                n_drop = 1'b1;
                            end
                        end
                        tfab_pkg::KIND_BUILD: begin
                            n_n        = NW'({r_count, 1'b0}) + NW'(r_count);
                            n_links    = '0;
                            n_adj_addr = '0;
                            n_state    = ST_CLRDEG;
                        end
                        tfab_pkg::KIND_QUERY: begin
                            n_q_ok     = r_deg_ok && (32'(i_query_face) < 32'(r_count));
                            n_adj_addr = FB'(i_query_face);
                            n_state    = ST_QWAIT;
                        end
                        default: begin
                            n_count  = '0;
                            n_drop   = 1'b0;
                            n_links  = '0;
                            n_deg_ok = 1'b0;
                        end
                    endcase
                end
            end
            ST_LOAD1: n_state = ST_LOAD2;
            ST_LOAD2: n_state = ST_IDLE;
            ST_CLRDEG: begin
                if (r_adj_addr == FB'(MAX_FACES - 1)) begin
                    n_w   = NW'(1);
                    n_s   = '0;
                    n_src = tfab_pkg::SEL_E;
                    n_dst = tfab_pkg::SEL_B;
                    n_state = (r_n > NW'(1)) ? ST_RUN : ST_OUT;
                end else begin
                    n_adj_addr = r_adj_addr + FB'(1);
                end
            end
            ST_RUN: begin
                n_m     = (s_w < r_n) ? s_w : r_n;
                n_e     = (s_2w < r_n) ? s_2w : r_n;
                n_i     = r_s;
                n_j     = (s_w < r_n) ? s_w : r_n;
                n_k     = r_s;
                n_state = ST_MRD;
            end
            ST_MRD: n_state = ST_MWR;
            ST_MWR: begin
                n_k = k1;
                if (take_j) begin
                    n_j = r_j + NW'(1);
                end else begin
                    n_i = r_i + NW'(1);
                end
                if (k1 == r_e) begin
                    if (s_2w >= r_n) begin
                        n_w   = w2;
                        n_s   = '0;
                        n_src = r_dst;
                        n_dst = (r_dst == tfab_pkg::SEL_B) ? tfab_pkg::SEL_C : tfab_pkg::SEL_B;
                        if (w2 >= r_n) begin
                            n_i     = '0;
                            n_j     = NW'(1);
                            n_state = ST_SRD;
                        end else begin
                            n_state = ST_RUN;
                        end
                    end else begin
                        n_s     = s_2w;
                        n_state = ST_RUN;
                    end
                end else begin
                    n_state = ST_MRD;
                end
            end
            ST_SRD: n_state = ST_SCMP;
            ST_SCMP: begin
                if (same) begin
                    n_links    = r_links + LW'(1);
                    n_pu       = rd0[FB-1:0];
                    n_pv       = rd1[FB-1:0];
                    n_adj_addr = rd0[FB-1:0];
                    n_state    = ST_PUWAIT;
                end else if (j1 < r_n) begin
                    n_i     = r_j;
                    n_j     = j1;
                    n_state = ST_SRD;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_PUWAIT: n_state = ST_PUWR;
            ST_PUWR: begin
                n_adj_addr = r_pv;
                n_state    = ST_PVWAIT;
            end
            ST_PVWAIT: n_state = ST_PVWR;
            ST_PVWR: begin
                if (j1 < r_n) begin
                    n_i     = r_j;
                    n_j     = j1;
                    n_state = ST_SRD;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_deg_ok  = 1'b1;
                    n_o_valid = 1'b1;
                    n_o_face  = tfab_pkg::FCNT_W'(r_count);
                    n_o_links = tfab_pkg::LCNT_W'(r_links);
                    n_o_ovf   = r_drop;
                    n_o_ncnt  = '0;
                    for (int t = 0; t < tfab_pkg::MAX_DEG; t++) begin
                        n_o_nbr[t] = '0;
                    end
                    n_state = ST_IDLE;
                end
            end
            ST_QWAIT: n_state = ST_QOUT;
            ST_QOUT: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_face  = tfab_pkg::FCNT_W'(r_count);
                    n_o_links = tfab_pkg::LCNT_W'(r_links);
                    n_o_ovf   = r_drop;
                    n_o_ncnt  = r_q_ok ? row_deg : '0;
                    for (int t = 0; t < tfab_pkg::MAX_DEG; t++) begin
                        n_o_nbr[t] = (r_q_ok && DW'(t) < row_deg)
                                     ? tfab_pkg::NBR_W'(adj_row[t*FB +: FB]) : '0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_drop    <= 1'b0;
            r_links   <= '0;
            r_deg_ok  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_drop    <= n_drop;
            r_links   <= n_links;
            r_deg_ok  <= n_deg_ok;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_va       <= n_va;
        r_vb       <= n_vb;
        r_vc       <= n_vc;
        r_face     <= n_face;
        r_base     <= n_base;
        r_n        <= n_n;
        r_w        <= n_w;
        r_s        <= n_s;
        r_i        <= n_i;
        r_j        <= n_j;
        r_k        <= n_k;
        r_m        <= n_m;
        r_e        <= n_e;
        r_src      <= n_src;
        r_dst      <= n_dst;
        r_adj_addr <= n_adj_addr;
        r_pu       <= n_pu;
        r_pv       <= n_pv;
        r_q_ok     <= n_q_ok;
        r_o_face   <= n_o_face;
        r_o_links  <= n_o_links;
        r_o_ovf    <= n_o_ovf;
        r_o_ncnt   <= n_o_ncnt;
        for (int t = 0; t < tfab_pkg::MAX_DEG; t++) begin
            r_o_nbr[t] <= n_o_nbr[t];
        end
    end

    assign o_valid           = r_o_valid;
    assign o_face_count      = r_o_face;
    assign o_link_count      = r_o_links;
    assign o_overflow        = r_o_ovf;
    assign o_neighbour_count = r_o_ncnt;
    assign o_neighbour_0     = r_o_nbr[0];
    assign o_neighbour_1     = r_o_nbr[1];
    assign o_neighbour_2     = r_o_nbr[2];
    assign o_neighbour_3     = r_o_nbr[3];
    assign o_neighbour_4     = r_o_nbr[4];
    assign o_neighbour_5     = r_o_nbr[5];

    a_merge_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MWR) |-> (r_k < r_e && r_i <= r_m && r_j <= r_e))
        else $error("merge indices out of run");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_FACES))
        else $error("face count above capacity");

    a_scan_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCMP) |-> (r_j == r_i + NW'(1) && r_j < r_n))
        else $error("scan pair out of range");

endmodule
